### hw/rtl/rps_pkg.sv
// Shared types and codes for the I2C register poll sequencer.
`default_nettype none

package rps_pkg;

    localparam int SLOT_W = 4;
    localparam int ADDR_W = 7;
    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        OP_START_POLL = 3'd0,
        OP_WRITE_REQ  = 3'd1,
        OP_STOP_DET   = 3'd2,
        OP_ACCESS_RDY = 3'd3,
        OP_LOAD_SLOT  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_SEND_NOSTOP = 3'd1,
        CMD_RESTART_RX  = 3'd2,
        CMD_WRITE_STOP  = 3'd3,
        CMD_STOP_CLR    = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_STOP_BUSY = 2'd1,
        ST_BUS_BUSY  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_RECV  = 3'd2,
        PH_WRITE = 3'd3,
        PH_RNACK = 3'd4,
        PH_WNACK = 3'd5
    } phase_t;

    // Byte counts carried with a command
    localparam logic [1:0] BC_NONE = 2'd0;
    localparam logic [1:0] BC_ONE  = 2'd1;
    localparam logic [1:0] BC_TWO  = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic              nack;
        logic              stop_pending;
        logic              bus_busy;
        logic [BYTE_W-1:0] rx_byte;
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_index;
        logic [BYTE_W-1:0] wr_byte;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] target_addr;
        logic [1:0]        byte_count;
        logic [BYTE_W-1:0] tx_first;
        logic [BYTE_W-1:0] tx_second;
        logic              data_valid;
        logic [SLOT_W-1:0] data_slot;
        logic [BYTE_W-1:0] data_byte;
        logic              send_done;
        logic [1:0]        status;
        logic              reinit_request;
    } result_t;

    // Slot table write port
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_index;
    } tbl_wr_t;

endpackage

`default_nettype wire

### hw/rtl/rps_slot_table.sv
// Poll slot table: device address and register per slot, flop array.
`default_nettype none

module rps_slot_table
    import rps_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire                      clk,
    input  tbl_wr_t                  wr,
    input  wire  [$clog2(DEPTH)-1:0] rd_slot,
    output logic [ADDR_W-1:0]        rd_dev,
    output logic [BYTE_W-1:0]        rd_reg
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [ADDR_W-1:0] dev_mem [DEPTH];
    logic [BYTE_W-1:0] reg_mem [DEPTH];

    // No reset: entries must only be read after a load; the table itself does not enforce this
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dev_mem[wr.slot[IDX_W-1:0]] <= wr.dev_addr;
            reg_mem[wr.slot[IDX_W-1:0]] <= wr.reg_index;
        end
    end

    assign rd_dev = dev_mem[rd_slot];
    assign rd_reg = reg_mem[rd_slot];

endmodule

`default_nettype wire

### hw/rtl/i2c_register_poll_sequencer.sv
// Top level of the I2C register poll sequencer: request register, step logic, result register.
// A request is held in the request register, decoded there by the step logic, and its result registered for m_*.
// Throughput: one request per cycle while m_* is not stalled; the only loop is the phase/pointer/done update.
// Backpressure on m_* propagates to s_tready in the same cycle; both stages hold when stalled.
// Reset (rst_n low, async): phase idle, poll pointer 0, done flag 0, both stages empty.
// The slot table is not cleared; a slot must be loaded before the poll reaches it.
`default_nettype none

module i2c_register_poll_sequencer
    import rps_pkg::*;
#(
    parameter int POLL_SLOTS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    // [0] nack, [1] stop_pending, [2] bus_busy, [10:3] rx_byte, [17:11] dev_addr,
    // [25:18] reg_index, [33:26] wr_byte, [37:34] slot, [39:38] zero
    input  wire  [39:0] s_tdata,
    // [2:0] opcode
    input  wire  [2:0]  s_tuser,

    output logic        m_tvalid,
    input  wire         m_tready,
    // [6:0] target_addr, [8:7] byte_count, [16:9] tx_first, [24:17] tx_second,
    // [25] data_valid, [29:26] data_slot, [37:30] data_byte, [38] send_done,
    // [40:39] status, [41] reinit_request, [47:42] zero
    output logic [47:0] m_tdata,
    // [2:0] command
    output logic [2:0]  m_tuser
);

    localparam int PTR_W       = $clog2(POLL_SLOTS);
    // Slot field is 4 bits, so only the first 16 slots can ever be loaded
    localparam int TABLE_DEPTH = (POLL_SLOTS < 16) ? POLL_SLOTS : 16;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(POLL_SLOTS - 1);

    // ---------------- request stage ----------------
    logic     in_valid_reg;
    in_item_t in_item_reg;
    in_item_t in_unpacked;
    logic     advance;

    assign in_unpacked.opcode       = s_tuser;
    assign in_unpacked.nack         = s_tdata[0];
    assign in_unpacked.stop_pending = s_tdata[1];
    assign in_unpacked.bus_busy     = s_tdata[2];
    assign in_unpacked.rx_byte      = s_tdata[10:3];
    assign in_unpacked.dev_addr     = s_tdata[17:11];
    assign in_unpacked.reg_index    = s_tdata[25:18];
    assign in_unpacked.wr_byte      = s_tdata[33:26];
    assign in_unpacked.slot         = s_tdata[37:34];

    // Step the request register into the result register when the output can take it
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_unpacked;
        end
    end

    // ---------------- sequencer state ----------------
    phase_t           phase_reg, phase_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             done_reg, done_next;

    opcode_t          op;
    status_t          start_st;
    logic [PTR_W-1:0] ptr_inc;
    logic             tbl_hit;
    tbl_wr_t          tbl_wr;
    logic [ADDR_W-1:0] rd_dev;
    logic [BYTE_W-1:0] rd_reg;

    assign op = opcode_t'(in_item_reg.opcode);

    // Start checks: pending stop wins over busy bus
    always_comb
    begin
        priority if (in_item_reg.stop_pending)
            start_st = ST_STOP_BUSY;
        else if (in_item_reg.bus_busy)
            start_st = ST_BUS_BUSY;
        else
            start_st = ST_OK;
    end

    assign ptr_inc = (ptr_reg == LAST_PTR) ? '0 : ptr_reg + PTR_W'(1);

    assign tbl_hit       = int'(in_item_reg.slot) < TABLE_DEPTH;
    assign tbl_wr.en     = advance && (op == OP_LOAD_SLOT) && tbl_hit;
    assign tbl_wr.slot   = in_item_reg.slot;
    assign tbl_wr.dev_addr  = in_item_reg.dev_addr;
    assign tbl_wr.reg_index = in_item_reg.reg_index;

    // Every table read in this design targets the pointer value after the step
    rps_slot_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_slot (TBL_IDX_W'(ptr_next)),
        .rd_dev  (rd_dev),
        .rd_reg  (rd_reg)
    );

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        done_next  = done_reg;
        unique case (op)
            OP_START_POLL:
            begin
                if (start_st == ST_OK)
                begin
                    ptr_next   = '0;
                    phase_next = PH_ADDR;
                end
            end
            OP_WRITE_REQ:
            begin
                if (start_st == ST_OK)
                begin
                    done_next  = 1'b0;
                    phase_next = PH_WRITE;
                end
            end
            OP_STOP_DET:
            begin
                unique case (phase_reg)
                    PH_WRITE:
                    begin
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    PH_RNACK:
                    begin
                        // Poll restart; a refused start keeps the phase for a retry
                        if (start_st == ST_OK)
                        begin
                            ptr_next   = '0;
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_WNACK:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_RECV:
                    begin
                        ptr_next   = ptr_inc;
                        phase_next = PH_ADDR;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            OP_ACCESS_RDY:
            begin
                if (in_item_reg.nack)
                begin
                    if (phase_reg == PH_ADDR)
                        phase_next = PH_RNACK;
                    else if (phase_reg == PH_WRITE)
                        phase_next = PH_WNACK;
                end
                else if (phase_reg == PH_ADDR)
                begin
                    phase_next = PH_RECV;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result of the step
    result_t res;

    always_comb
    begin
        res           = '0;
        res.command   = CMD_NONE;
        res.status    = ST_OK;
        unique case (op)
            OP_START_POLL:
            begin
                res.status = start_st;
                if (start_st == ST_OK)
                begin
                    res.command     = CMD_SEND_NOSTOP;
                    res.target_addr = rd_dev;
                    res.byte_count  = BC_ONE;
                    res.tx_first    = rd_reg;
                end
            end
            OP_WRITE_REQ:
            begin
                res.status = start_st;
                if (start_st == ST_OK)
                begin
                    res.command     = CMD_WRITE_STOP;
                    res.target_addr = in_item_reg.dev_addr;
                    res.byte_count  = BC_TWO;
                    res.tx_first    = in_item_reg.reg_index;
                    res.tx_second   = in_item_reg.wr_byte;
                end
            end
            OP_STOP_DET:
            begin
                unique case (phase_reg)
                    PH_RNACK:
                    begin
                        res.status = start_st;
                        if (start_st == ST_OK)
                        begin
                            res.command     = CMD_SEND_NOSTOP;
                            res.target_addr = rd_dev;
                            res.byte_count  = BC_ONE;
                            res.tx_first    = rd_reg;
                        end
                    end
                    PH_WNACK:
                    begin
                        res.reinit_request = 1'b1;
                    end
                    PH_RECV:
                    begin
                        // Deliver the byte, then address the next slot
                        res.data_valid  = 1'b1;
                        res.data_slot   = SLOT_W'(ptr_reg);
                        res.data_byte   = in_item_reg.rx_byte;
                        res.command     = CMD_SEND_NOSTOP;
                        res.target_addr = rd_dev;
                        res.byte_count  = BC_ONE;
                        res.tx_first    = rd_reg;
                    end
                    default:
                    begin
                        res.command = CMD_NONE;
                    end
                endcase
            end
            OP_ACCESS_RDY:
            begin
                if (in_item_reg.nack)
                begin
                    res.command = CMD_STOP_CLR;
                end
                else if (phase_reg == PH_ADDR)
                begin
                    res.command     = CMD_RESTART_RX;
                    res.target_addr = rd_dev;
                    res.byte_count  = BC_ONE;
                end
            end
            default:
            begin
                res.command = CMD_NONE;
            end
        endcase
        res.send_done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    // ---------------- result stage ----------------
    logic    out_valid_reg;
    result_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.command;
    assign m_tdata  = {6'd0,
                       out_res_reg.reinit_request,
                       out_res_reg.status,
                       out_res_reg.send_done,
                       out_res_reg.data_byte,
                       out_res_reg.data_slot,
                       out_res_reg.data_valid,
                       out_res_reg.tx_second,
                       out_res_reg.tx_first,
                       out_res_reg.byte_count,
                       out_res_reg.target_addr};

endmodule

`default_nettype wire

### hw/rtl/rps_checker.sv
// Port-level checker for the I2C register poll sequencer, with its bind.
`default_nettype none

module rps_checker
    import rps_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire [2:0]  m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A refused start issues no command
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[40:39] != ST_OK) |-> m_tuser == CMD_NONE)
        else $error("command issued with nonzero status");

    // A delivered byte always comes with the address phase of the next slot
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25] |-> m_tuser == CMD_SEND_NOSTOP && m_tdata[8:7] == BC_ONE)
        else $error("polled byte without next address phase");

    // Reinit request only on a quiet result
    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41] |-> m_tuser == CMD_NONE && !m_tdata[25])
        else $error("reinit request with a command");

endmodule

bind i2c_register_poll_sequencer rps_checker u_rps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
